/* sv/text_console_cell_writer_assert.svh */
// Assertion macros for the text console cell writer.
// Shared by every RTL file that checks its own logic; no dependencies.
`ifndef TEXT_CONSOLE_CELL_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CELL_WRITER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define TCCW_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tccw assertion failed");

// next-cycle implication
`define TCCW_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tccw assertion failed");

`else

`define TCCW_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define TCCW_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* sv/tccw_pkg.sv */
// Package for the text console cell writer: field widths, codes and item types.
// No dependencies.
package tccw_pkg;

   localparam int unsigned CHAR_W   = 8;
   localparam int unsigned ATTR_W   = 8;
   localparam int unsigned OFFSET_W = 32;
   localparam int unsigned POS_W    = 11;
   localparam int unsigned WORD_W   = 16;

   localparam logic [ATTR_W-1:0] TEXT_COLOR_RESET = 8'h07;

   typedef enum logic {
      MODE_WRITE = 1'b0,
      MODE_SEEK  = 1'b1
   } mode_type;

   typedef struct packed {
      mode_type                mode;
      logic [CHAR_W-1:0]       char_code;
      logic [OFFSET_W-1:0]     seek_offset;
   } item_type;

   typedef struct packed {
      logic                    cell_write;
      logic [POS_W-1:0]        cell_index;
      logic [WORD_W-1:0]       cell_word;
      logic [POS_W-1:0]        cursor_pos;
   } result_type;

endpackage

/* sv/tccw_req_if.sv */
// Request channel of the text console cell writer.
// Depends on tccw_pkg.
interface tccw_req_if
   import tccw_pkg::*;
();
   logic                valid;
   logic                ready;
   logic                mode;
   logic [CHAR_W-1:0]   char_code;
   logic [OFFSET_W-1:0] seek_offset;

   modport source (output valid, mode, char_code, seek_offset, input ready);
   modport sink   (input valid, mode, char_code, seek_offset, output ready);
endinterface

/* sv/tccw_rsp_if.sv */
// Response channel of the text console cell writer.
// Depends on tccw_pkg.
interface tccw_rsp_if
   import tccw_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              cell_write;
   logic [POS_W-1:0]  cell_index;
   logic [WORD_W-1:0] cell_word;
   logic [POS_W-1:0]  cursor_pos;

   modport source (output valid, cell_write, cell_index, cell_word, cursor_pos, input ready);
   modport sink   (input valid, cell_write, cell_index, cell_word, cursor_pos, output ready);
endinterface

/* sv/tccw_csr_if.sv */
// Register write channel of the text console cell writer (text colour only).
// Depends on tccw_pkg.
interface tccw_csr_if
   import tccw_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [ATTR_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

/* sv/text_console_cell_writer.sv */
// Text console cell writer: cursor into a COLUMNS x ROWS screen, cell writes and seeks.
// Depends on tccw_pkg, the three channel interfaces and the tccw_*_stage modules.
//
//   channel  | dir | handshake   | carries
//   req_port | in  | valid/ready | mode, char_code, seek_offset
//   rsp_port | out | valid/ready | cell_write, cell_index, cell_word, cursor_pos
//   csr_port | in  | valid/ready | text colour byte (always ready)
//
// One item per cycle sustained while rsp_port is ready; items pass the input, quot, resid and cursor registers.
// The rate is set by the cursor update loop in the cursor stage (one increment-and-wrap
// or load per cycle); the seek reduction is spread over the quotient and residue stages.
// Each stage takes a new item while its downstream stage is empty or moving; a stalled
// response holds only the stages behind it once they fill.
// Synchronous reset clears valids and the cursor; text colour resets to 7. No clearing pass.
module text_console_cell_writer
   import tccw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic    clock,
   input  logic    reset,
   tccw_req_if.sink   req_port,
   tccw_rsp_if.source rsp_port,
   tccw_csr_if.sink   csr_port
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int CUR_W = (CELLS > (1 << POS_W)) ? $clog2(CELLS) : POS_W;

   logic [ATTR_W-1:0] text_color_ff, text_color_in;

   logic              in_valid_ff, in_valid_in;
   item_type          in_item_ff;
   logic              in_ready;

   logic                q_valid, q_ready;
   item_type            q_item;
   logic [OFFSET_W-1:0] q_quot;

   logic             r_valid, r_ready;
   mode_type         r_mode;
   logic [CHAR_W-1:0] r_char;
   logic [CUR_W-1:0] r_resid;

   result_type       result;

   // register port
   assign csr_port.ready = 1'b1;
   assign text_color_in  = csr_port.valid ? csr_port.data : text_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff <= TEXT_COLOR_RESET;
      end else begin
         text_color_ff <= text_color_in;
      end
   end

   // input register
   assign req_port.ready = !in_valid_ff || in_ready;
   assign in_valid_in    = req_port.ready ? req_port.valid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_port.valid && req_port.ready) begin
         in_item_ff.mode        <= mode_type'(req_port.mode);
         in_item_ff.char_code   <= req_port.char_code;
         in_item_ff.seek_offset <= req_port.seek_offset;
      end
   end

   tccw_quot_stage #(
      .CELLS (CELLS)
   ) u_quot (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_ready  (in_ready),
      .in_item   (in_item_ff),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item),
      .out_quot  (q_quot)
   );

   tccw_resid_stage #(
      .CELLS (CELLS),
      .CUR_W (CUR_W)
   ) u_resid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_item   (q_item),
      .in_quot   (q_quot),
      .out_valid (r_valid),
      .out_ready (r_ready),
      .out_mode  (r_mode),
      .out_char  (r_char),
      .out_resid (r_resid)
   );

   tccw_cursor_stage #(
      .CELLS (CELLS),
      .CUR_W (CUR_W)
   ) u_cursor (
      .clock      (clock),
      .reset      (reset),
      .text_color (text_color_ff),
      .in_valid   (r_valid),
      .in_ready   (r_ready),
      .in_mode    (r_mode),
      .in_char    (r_char),
      .in_resid   (r_resid),
      .out_valid  (rsp_port.valid),
      .out_ready  (rsp_port.ready),
      .out_result (result)
   );

   assign rsp_port.cell_write = result.cell_write;
   assign rsp_port.cell_index = result.cell_index;
   assign rsp_port.cell_word  = result.cell_word;
   assign rsp_port.cursor_pos = result.cursor_pos;

endmodule

/* sv/tccw_quot_stage.sv */
// Quotient stage: estimates seek_offset / cells with a reciprocal multiply.
// Depends on tccw_pkg.
module tccw_quot_stage
   import tccw_pkg::*;
#(
   parameter int CELLS = 2000
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  item_type            in_item,
   output logic                out_valid,
   input  logic                out_ready,
   output item_type            out_item,
   output logic [OFFSET_W-1:0] out_quot
);

   // floor(2^32 / cells); estimate is low by at most one
   localparam logic [OFFSET_W:0] RECIP = (OFFSET_W+1)'((64'd1 << OFFSET_W) / CELLS);

   logic                    valid_ff, valid_in;
   item_type                item_ff;
   logic [OFFSET_W-1:0]     quot_ff;
   logic [2*OFFSET_W-1:0]   prod;

   assign prod     = (2*OFFSET_W)'(in_item.seek_offset) * (2*OFFSET_W)'(RECIP);
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
         quot_ff <= prod[2*OFFSET_W-1:OFFSET_W];
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
   assign out_quot  = quot_ff;

endmodule

/* sv/tccw_resid_stage.sv */
// Residue stage: seek_offset minus quotient times cells, one correcting subtract.
// Depends on tccw_pkg.
module tccw_resid_stage
   import tccw_pkg::*;
#(
   parameter int CELLS = 2000,
   parameter int CUR_W = 11
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  item_type            in_item,
   input  logic [OFFSET_W-1:0] in_quot,
   output logic                out_valid,
   input  logic                out_ready,
   output mode_type            out_mode,
   output logic [CHAR_W-1:0]   out_char,
   output logic [CUR_W-1:0]    out_resid
);

   logic                valid_ff, valid_in;
   mode_type            mode_ff;
   logic [CHAR_W-1:0]   char_ff;
   logic [CUR_W-1:0]    resid_ff, resid_in;
   logic [OFFSET_W-1:0] rem_raw, rem_fix;

   assign rem_raw  = in_item.seek_offset - in_quot * OFFSET_W'(CELLS);
   assign rem_fix  = (rem_raw >= OFFSET_W'(CELLS)) ? rem_raw - OFFSET_W'(CELLS) : rem_raw;
   assign resid_in = rem_fix[CUR_W-1:0];
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         mode_ff  <= in_item.mode;
         char_ff  <= in_item.char_code;
         resid_ff <= resid_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_mode  = mode_ff;
   assign out_char  = char_ff;
   assign out_resid = resid_ff;

endmodule

/* sv/tccw_cursor_stage.sv */
// Cursor stage: holds the cursor, forms the cell write and the response register.
// Depends on tccw_pkg and text_console_cell_writer_assert.svh.
`include "text_console_cell_writer_assert.svh"

module tccw_cursor_stage
   import tccw_pkg::*;
#(
   parameter int CELLS = 2000,
   parameter int CUR_W = 11
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [ATTR_W-1:0] text_color,
   input  logic              in_valid,
   output logic              in_ready,
   input  mode_type          in_mode,
   input  logic [CHAR_W-1:0] in_char,
   input  logic [CUR_W-1:0]  in_resid,
   output logic              out_valid,
   input  logic              out_ready,
   output result_type        out_result
);

   logic             valid_ff, valid_in;
   logic [CUR_W-1:0] cursor_ff, cursor_in;
   result_type       result_ff, result_in;
   logic             take, last, is_write;
   logic [CUR_W-1:0] step;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;
   assign is_write = (in_mode == MODE_WRITE);
   assign last     = (cursor_ff == CUR_W'(CELLS - 1));
   assign step     = last ? '0 : cursor_ff + 1'b1;

   always_comb begin
      cursor_in = cursor_ff;
      if (take) begin
         cursor_in = is_write ? step : in_resid;
      end
   end

   always_comb begin
      result_in.cell_write = is_write;
      result_in.cell_index = is_write ? cursor_ff[POS_W-1:0] : '0;
      result_in.cell_word  = is_write ? {text_color, in_char} : '0;
      result_in.cursor_pos = cursor_in[POS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         cursor_ff <= '0;
      end else begin
         valid_ff  <= valid_in;
         cursor_ff <= cursor_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         result_ff <= result_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

   `TCCW_ASSERT_IMP(a_cursor_in_range, clock, reset, 1'b1, {1'b0, cursor_ff} < (CUR_W+1)'(CELLS))
   `TCCW_ASSERT_NEXT(a_write_advances, clock, reset, take && is_write && !last, cursor_ff == $past(cursor_ff) + 1'b1)
   `TCCW_ASSERT_NEXT(a_seek_loads, clock, reset, take && !is_write, cursor_ff == $past(in_resid))
   `TCCW_ASSERT_NEXT(a_rsp_cursor, clock, reset, take, valid_ff && result_ff.cursor_pos == cursor_ff[POS_W-1:0])

endmodule

/* sim/text_console_cell_writer_checker.sv */
// Checker for the text console cell writer: follows the cursor and text colour,
// predicts every response and compares it field by field. Depends on tccw_pkg and
// the three channel interfaces.
module text_console_cell_writer_checker
   import tccw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic  clock,
   input  logic  reset,
   tccw_req_if   req_mon,
   tccw_rsp_if   rsp_mon,
   tccw_csr_if   csr_mon,
   output int    errors,
   output int    pending
);

   localparam int unsigned CELLS = (COLUMNS * ROWS == 0) ? 1 : COLUMNS * ROWS;

   int unsigned       cursor;
   logic [ATTR_W-1:0] text_colour;
   result_type        expected_cells[$];

   initial begin
      errors  = 0;
      pending = 0;
   end

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t: %s", $realtime, what);
      errors++;
   endtask

   // cursor update and cell contents for one accepted item
   function automatic result_type predict_cell_write(input item_type it);
      result_type  r;
      int unsigned at;
      r = '0;
      if (cursor >= CELLS)
         cursor = cursor % CELLS;
      if (it.mode == MODE_WRITE) begin
         at = cursor;
         cursor = (at + 1 >= CELLS) ? 0 : at + 1;
         r.cell_write = 1'b1;
         r.cell_index = at[POS_W-1:0];
         r.cell_word  = {text_colour, it.char_code};
      end else begin
         cursor = it.seek_offset % CELLS;
      end
      r.cursor_pos = cursor[POS_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      item_type   it;
      result_type want;
      if (reset) begin
         cursor      = 0;
         text_colour = TEXT_COLOR_RESET;
         expected_cells.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready)
            text_colour = csr_mon.data;
         if (req_mon.valid && req_mon.ready) begin
            it.mode        = mode_type'(req_mon.mode);
            it.char_code   = req_mon.char_code;
            it.seek_offset = req_mon.seek_offset;
            expected_cells.push_back(predict_cell_write(it));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_cells.size() == 0) begin
               report_mismatch("response with no item outstanding");
            end else begin
               want = expected_cells.pop_front();
               if (rsp_mon.cell_write !== want.cell_write)
                  report_mismatch($sformatf("cell_write got %b want %b",
                     rsp_mon.cell_write, want.cell_write));
               if (rsp_mon.cell_index !== want.cell_index)
                  report_mismatch($sformatf("cell_index got %0d want %0d",
                     rsp_mon.cell_index, want.cell_index));
               if (rsp_mon.cell_word !== want.cell_word)
                  report_mismatch($sformatf("cell_word got %h want %h",
                     rsp_mon.cell_word, want.cell_word));
               if (rsp_mon.cursor_pos !== want.cursor_pos)
                  report_mismatch($sformatf("cursor_pos got %0d want %0d",
                     rsp_mon.cursor_pos, want.cursor_pos));
            end
         end
      end
      pending <= expected_cells.size();
   end

endmodule

/* sim/text_console_cell_writer_tb.sv */
// Top of the text console cell writer testbench: clock, reset, item and colour
// stimulus, response stalls and the verdict. Depends on tccw_pkg, the channel
// interfaces, the block and text_console_cell_writer_checker.
module text_console_cell_writer_tb;
   import tccw_pkg::*;

   localparam int COLUMNS        = 80;
   localparam int ROWS           = 25;
   localparam int unsigned CELLS = COLUMNS * ROWS;
   localparam int CLK_PERIOD     = 10;
   localparam int TIMEOUT_CYCLES = 200000;
   localparam int RANDOM_ITEMS   = 170;

   logic clock = 1'b0;
   logic reset;
   logic calm;
   int   errors;
   int   pending;

   tccw_req_if req_ch ();
   tccw_rsp_if rsp_ch ();
   tccw_csr_if csr_ch ();

   text_console_cell_writer #(.COLUMNS(COLUMNS), .ROWS(ROWS)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch),
      .csr_port (csr_ch)
   );

   text_console_cell_writer_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) checker_inst (
      .clock   (clock),
      .reset   (reset),
      .req_mon (req_ch),
      .rsp_mon (rsp_ch),
      .csr_mon (csr_ch),
      .errors  (errors),
      .pending (pending)
   );

   always begin
      #(CLK_PERIOD / 2) clock = 1'b1;
      #(CLK_PERIOD / 2) clock = 1'b0;
   end

   initial begin
      #(CLK_PERIOD * TIMEOUT_CYCLES);
      $display("DONE: errors detected");
      $finish;
   end

   // response side: random stall before each item
   initial begin
      int gap;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = calm ? 0 : $urandom_range(0, 8);
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
      end
   end

   function automatic item_type write_item(input logic [CHAR_W-1:0] ch);
      item_type it;
      it.mode        = MODE_WRITE;
      it.char_code   = ch;
      it.seek_offset = $urandom;
      return it;
   endfunction

   function automatic item_type seek_item(input logic [OFFSET_W-1:0] offset);
      item_type it;
      it.mode        = MODE_SEEK;
      it.char_code   = CHAR_W'($urandom);
      it.seek_offset = offset;
      return it;
   endfunction

   // mostly writes; random seeks, large-offset seeks and seeks near the last cell so the following writes wrap
   function automatic item_type random_item();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 72)
         return write_item(CHAR_W'($urandom));
      else if (pick < 84)
         return seek_item($urandom);
      else if (pick < 94)
         return seek_item(CELLS - $urandom_range(1, 6));
      else
         return seek_item($urandom_range(0, 2147000) * CELLS + $urandom_range(0, CELLS - 1));
   endfunction

   task automatic send_item(input item_type it);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.mode        <= it.mode;
      req_ch.char_code   <= it.char_code;
      req_ch.seek_offset <= it.seek_offset;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_colour(input logic [ATTR_W-1:0] colour);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= colour;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic run_random(input int count);
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0)
            calm = ($urandom_range(0, 3) == 0);
         send_item(random_item());
      end
   endtask

   initial begin
      calm               = 1'b0;
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.mode        <= MODE_WRITE;
      req_ch.char_code   <= '0;
      req_ch.seek_offset <= '0;
      csr_ch.valid       <= 1'b0;
      csr_ch.data        <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed, reset colour
      send_item(write_item(8'h00));
      send_item(write_item(8'hFF));
      send_item(write_item(8'h5A));
      send_item(seek_item(32'd0));
      send_item(seek_item(CELLS - 1));
      send_item(write_item(8'hA5));
      send_item(seek_item(CELLS));
      send_item(seek_item(32'hFFFF_FFFF));
      send_item(write_item(8'h41));
      send_item(seek_item(32'h8000_0000));
      send_item(seek_item(2 * CELLS + CELLS - 2));
      send_item(write_item(8'h01));
      send_item(write_item(8'h80));
      send_item(write_item(8'h7F));
      send_item(seek_item(32'd1));
      send_item(write_item(8'h00));
      send_item(seek_item(32'h7FFF_FFFF));
      send_item(write_item(8'hFF));
      send_item(seek_item(32'h5555_5555));
      send_item(seek_item(32'hAAAA_AAAA));
      send_item(write_item(8'h20));
      drain();

      write_colour(8'h00);
      run_random(RANDOM_ITEMS);
      drain();
      write_colour(8'hFF);
      run_random(RANDOM_ITEMS);
      drain();
      write_colour(ATTR_W'($urandom));
      run_random(RANDOM_ITEMS);
      drain();
      write_colour(8'hA5);
      run_random(RANDOM_ITEMS);
      drain();
      write_colour(8'h5A);
      run_random(RANDOM_ITEMS);

      drain();
      repeat (8) @(posedge clock);
      if (errors == 0 && pending == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

/* text_console_cell_writer.f */
+incdir+sv
sv/tccw_pkg.sv
sv/tccw_req_if.sv
sv/tccw_rsp_if.sv
sv/tccw_csr_if.sv
sv/tccw_quot_stage.sv
sv/tccw_resid_stage.sv
sv/tccw_cursor_stage.sv
sv/text_console_cell_writer.sv
sim/text_console_cell_writer_checker.sv
sim/text_console_cell_writer_tb.sv
